### rtl/core/stereo_soft_clip_output_top_defines.svh
// Assertion macros for the soft clip output block.
`ifndef STEREO_SOFT_CLIP_OUTPUT_TOP_DEFINES_SVH
`define STEREO_SOFT_CLIP_OUTPUT_TOP_DEFINES_SVH

`ifndef SYNTH
`define SCC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SCC_ASSERT_SAME(label, ante, cons)
`define SCC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/scc_pkg.sv
`timescale 1ns / 1ps

package scc_pkg;

  localparam int SAMPLE_W = 32;
  localparam int OUT_W    = 16;
  localparam int MAG_W    = 31;
  localparam int Y_W      = 15;
  localparam int FRAME_W  = 14;
  localparam int BLEN_W   = 15;
  localparam int CIDX_W   = 2;
  localparam int QW       = 13;
  localparam int NUM_W    = MAG_W + QW;
  localparam int NSTG     = 3 + QW;

  localparam logic [MAG_W-1:0] KNEE  = MAG_W'(24576);
  localparam logic [MAG_W-1:0] RANGE = MAG_W'(8191);

  typedef enum logic [CIDX_W-1:0] {
    REG_OUTPUT_ENABLE = 2'd0,
    REG_BLOCK_LENGTH  = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [NSTG-1:0] ld;
  } ctrl_t;

  typedef struct packed {
    logic [QW-1:0]  q;
    logic [Y_W-1:0] mag;
    logic           neg;
    logic           knee;
  } lane_res_t;

endpackage

### rtl/core/scc_lane.sv
`timescale 1ns / 1ps

module scc_lane (
  input  logic                             clk,
  input  scc_pkg::ctrl_t                   ctrl,
  input  logic signed [scc_pkg::SAMPLE_W-1:0] sample,
  output scc_pkg::lane_res_t               res
);

  localparam int QW    = scc_pkg::QW;
  localparam int MAG_W = scc_pkg::MAG_W;
  localparam int NUM_W = scc_pkg::NUM_W;
  localparam int Y_W   = scc_pkg::Y_W;

  logic [scc_pkg::SAMPLE_W-1:0] negv;
  logic [MAG_W-1:0]             mag_in;

  logic [MAG_W-1:0] mag0;
  logic             neg0;
  logic [MAG_W-1:0] over1;
  logic [Y_W-1:0]   mag1;
  logic             neg1;
  logic             knee1;

  logic [NUM_W-1:0] rem  [QW+1];
  logic [MAG_W-1:0] den  [QW+1];
  logic [QW-1:0]    quo  [QW+1];
  logic [Y_W-1:0]   magp [QW+1];
  logic             negp [QW+1];
  logic             knp  [QW+1];

  always_comb begin
    negv = -sample;
    if (sample[scc_pkg::SAMPLE_W-1]) begin
      mag_in = negv[scc_pkg::SAMPLE_W-1] ? '1 : negv[MAG_W-1:0];
    end else begin
      mag_in = sample[MAG_W-1:0];
    end
  end

  // magnitude with saturation of the most negative value
  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) begin
      mag0 <= mag_in;
      neg0 <= sample[scc_pkg::SAMPLE_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[1]) begin
      knee1 <= (mag0 <= scc_pkg::KNEE);
      over1 <= (mag0 <= scc_pkg::KNEE) ? '0 : mag0 - scc_pkg::KNEE;
      mag1  <= mag0[Y_W-1:0];
      neg1  <= neg0;
    end
  end

  // numerator 8191*over, denominator over+8191
  always_ff @(posedge clk) begin
    if (ctrl.ld[2]) begin
      rem[0]  <= {over1, {QW{1'b0}}} - NUM_W'(over1);
      den[0]  <= over1 + scc_pkg::RANGE;
      quo[0]  <= '0;
      magp[0] <= mag1;
      negp[0] <= neg1;
      knp[0]  <= knee1;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int BIT = QW - 1 - k;
    logic [NUM_W-1:0] dsh;
    logic             ge;
    logic [QW-1:0]    qn;

    always_comb begin
      dsh     = NUM_W'(den[k]) << BIT;
      ge      = (rem[k] >= dsh);
      qn      = quo[k];
      qn[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (ctrl.ld[3+k]) begin
        rem[k+1]  <= ge ? rem[k] - dsh : rem[k];
        den[k+1]  <= den[k];
        quo[k+1]  <= qn;
        magp[k+1] <= magp[k];
        negp[k+1] <= negp[k];
        knp[k+1]  <= knp[k];
      end
    end
  end

  always_comb begin
    res.q    = quo[QW];
    res.mag  = magp[QW];
    res.neg  = negp[QW];
    res.knee = knp[QW];
  end

endmodule

### rtl/core/scc_merge.sv
`timescale 1ns / 1ps
`include "stereo_soft_clip_output_top_defines.svh"

module scc_merge (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             vld_in,
  input  logic                             silent,
  input  scc_pkg::lane_res_t               res_l,
  input  scc_pkg::lane_res_t               res_r,
  output logic                             ready,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [scc_pkg::OUT_W-1:0] left_out,
  output logic signed [scc_pkg::OUT_W-1:0] right_out
);

  localparam int OUT_W = scc_pkg::OUT_W;
  localparam int Y_W   = scc_pkg::Y_W;

  logic             ld;
  logic [OUT_W-1:0] l_next;
  logic [OUT_W-1:0] r_next;

  function automatic logic [OUT_W-1:0] shape(scc_pkg::lane_res_t r);
    logic [Y_W-1:0] y;
    y = r.knee ? r.mag : Y_W'(scc_pkg::KNEE) + Y_W'(r.q);
    return r.neg ? -{1'b0, y} : {1'b0, y};
  endfunction

  assign ready = !out_valid || !out_stall;
  assign ld    = ready && vld_in;

  always_comb begin
    l_next = silent ? '0 : shape(res_l);
    r_next = silent ? '0 : shape(res_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      left_out  <= l_next;
      right_out <= r_next;
    end
  end

  `SCC_ASSERT_SAME(a_no_min_code, out_valid,
    left_out != 16'sh8000 && right_out != 16'sh8000)
  `SCC_ASSERT_NEXT(a_silent_zero, ld && silent, left_out == '0 && right_out == '0)
  `SCC_ASSERT_NEXT(a_knee_pass, ld && !silent && res_l.knee,
    left_out <= 16'sd24576 && left_out >= -16'sd24576)

endmodule

### rtl/core/stereo_soft_clip_output_top.sv
`timescale 1ns / 1ps
`include "stereo_soft_clip_output_top_defines.svh"

// Stereo soft clipper: 32-bit mixed PCM frame in, two 16-bit samples out.
// Input channel: in_valid/in_stall with left_sample, right_sample,
// pcm_available and frame_index. A transfer happens when in_valid is high
// and in_stall is low. Output channel: out_valid/out_stall with left_out and
// right_out, one result per input frame, in order.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 output_enable,
// 1 block_length) and cfg_data; cfg_ready is always high, other indexes
// are ignored. Write config only while the block is empty.
// The frame passes 17 register stages, the first loaded at the input
// transfer edge: three of magnitude and operand setup, thirteen restoring
// divider stages (one quotient bit each, one per lane), and the output
// register. Throughput is one frame per cycle while out_stall is low.
// When out_stall holds a result, the stages behind it keep filling until
// they are all occupied, and only then is in_stall raised. Reset (rst,
// synchronous) empties the pipeline and clears output_enable and
// block_length to zero.
module stereo_soft_clip_output_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [scc_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [scc_pkg::SAMPLE_W-1:0] right_sample,
  input  logic                                pcm_available,
  input  logic [scc_pkg::FRAME_W-1:0]         frame_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [scc_pkg::OUT_W-1:0]    left_out,
  output logic signed [scc_pkg::OUT_W-1:0]    right_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scc_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [scc_pkg::BLEN_W-1:0]          cfg_data
);

  localparam int NSTG = scc_pkg::NSTG;

  logic                        output_enable;
  logic [scc_pkg::BLEN_W-1:0]  block_length;
  logic [NSTG-1:0]             vld;
  logic                        sil [NSTG];
  logic [NSTG:0]               rdy;
  logic                        sil_in;
  scc_pkg::ctrl_t              ctrl;
  scc_pkg::lane_res_t          res_l;
  scc_pkg::lane_res_t          res_r;
  logic                        merge_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_enable <= 1'b0;
      block_length  <= '0;
    end else if (cfg_valid) begin
      case (scc_pkg::reg_idx_t'(cfg_index))
        scc_pkg::REG_OUTPUT_ENABLE: output_enable <= cfg_data[0];
        scc_pkg::REG_BLOCK_LENGTH:  block_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sil_in = !output_enable || !pcm_available ||
                  ({1'b0, frame_index} >= block_length);

  // per-stage ready chain, a stage loads when empty or when it drains
  always_comb begin
    rdy[NSTG] = merge_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    ctrl.ld[0] = rdy[0] && in_valid;
    for (int k = 1; k < NSTG; k++) begin
      ctrl.ld[k] = rdy[k] && vld[k-1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) sil[0] <= sil_in;
    for (int k = 1; k < NSTG; k++) begin
      if (ctrl.ld[k]) sil[k] <= sil[k-1];
    end
  end

  scc_lane u_lane_l (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (left_sample),
    .res    (res_l)
  );

  scc_lane u_lane_r (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (right_sample),
    .res    (res_r)
  );

  scc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .vld_in    (vld[NSTG-1]),
    .silent    (sil[NSTG-1]),
    .res_l     (res_l),
    .res_r     (res_r),
    .ready     (merge_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out)
  );

  `SCC_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, vld[0])
  `SCC_ASSERT_SAME(a_stall_full, in_stall, vld == '1)

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [31:0] KNEE_LEVEL = 32'd24576;
  localparam logic [31:0] PEAK_LEVEL = 32'd32767;
  localparam logic [31:0] CURVE_SPAN = PEAK_LEVEL - KNEE_LEVEL;
  localparam logic [scc_pkg::CIDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [scc_pkg::CIDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int DRAIN_SLACK = 24;
  localparam int FRAMES_PER_PHASE = 95;

  typedef struct packed {
    logic signed [scc_pkg::OUT_W-1:0] left_val;
    logic signed [scc_pkg::OUT_W-1:0] right_val;
  } stereo_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [scc_pkg::SAMPLE_W-1:0] left_sample = '0;
  logic signed [scc_pkg::SAMPLE_W-1:0] right_sample = '0;
  logic pcm_available = 1'b0;
  logic [scc_pkg::FRAME_W-1:0] frame_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [scc_pkg::OUT_W-1:0] left_out;
  logic signed [scc_pkg::OUT_W-1:0] right_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [scc_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [scc_pkg::BLEN_W-1:0] cfg_data = '0;

  logic live_enable = 1'b0;
  logic [scc_pkg::BLEN_W-1:0] live_block_len = '0;
  stereo_out_t clipped_frames[$];
  int fail_count = 0;
  logic src_quiet = 1'b0;
  logic sink_quiet = 1'b0;
  int unsigned stall_hold = 0;

  stereo_soft_clip_output_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .left_sample(left_sample),
    .right_sample(right_sample),
    .pcm_available(pcm_available),
    .frame_index(frame_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .left_out(left_out),
    .right_out(right_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [15:0] clip_sample(input logic [31:0] raw);
    logic        neg;
    logic [31:0] mag;
    logic [63:0] over;
    logic [63:0] extra;
    logic [63:0] level;
    logic [15:0] y;
    neg = raw[31];
    mag = neg ? (32'd0 - raw) : raw;
    if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
    if (mag <= KNEE_LEVEL) begin
      y = mag[15:0];
    end else begin
      over = 64'(mag - KNEE_LEVEL);
      extra = (64'(CURVE_SPAN) * over) / (over + 64'(CURVE_SPAN));
      level = 64'(KNEE_LEVEL) + extra;
      if (level > 64'(PEAK_LEVEL)) level = 64'(PEAK_LEVEL);
      y = level[15:0];
    end
    return neg ? 16'(16'd0 - y) : y;
  endfunction

  function automatic stereo_out_t clip_frame(input logic [31:0] l, input logic [31:0] r,
                                             input logic avail, input logic [13:0] idx);
    stereo_out_t res;
    res = '0;
    if (live_enable && avail && {1'b0, idx} < live_block_len) begin
      res.left_val = clip_sample(l);
      res.right_val = clip_sample(r);
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (src_quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [31:0] rand_sample();
    int unsigned p;
    logic [31:0] mag;
    p = $urandom_range(0, 99);
    if (p < 35) return $urandom;
    if (p < 65) mag = $urandom_range(0, 60000);
    else if (p < 80) mag = $urandom_range(24000, 25200);
    else if (p < 92) mag = $urandom_range(0, 24576);
    else begin
      case ($urandom_range(0, 5))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h8000_0001;
        3: return 32'd0;
        4: mag = KNEE_LEVEL;
        default: mag = KNEE_LEVEL + 1;
      endcase
    end
    return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
  endfunction

  function automatic logic [13:0] rand_frame_index();
    int lo;
    int hi;
    if ($urandom_range(0, 1) || live_block_len == 0) return 14'($urandom_range(0, 16383));
    hi = int'(live_block_len) + 2;
    if (hi > 16383) hi = 16383;
    lo = int'(live_block_len) - 3;
    if (lo < 0) lo = 0;
    if (lo > hi) lo = hi;
    return 14'($urandom_range(hi, lo));
  endfunction

  task automatic send_frame(input logic [31:0] l, input logic [31:0] r,
                            input logic avail, input logic [13:0] idx);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_sample <= l;
    right_sample <= r;
    pcm_available <= avail;
    frame_index <= idx;
    do @(posedge clk); while (in_stall);
    clipped_frames.push_back(clip_frame(l, r, avail, idx));
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (clipped_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [scc_pkg::CIDX_W-1:0] idx,
                           input logic [scc_pkg::BLEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == scc_pkg::REG_OUTPUT_ENABLE) live_enable = value[0];
    else if (idx == scc_pkg::REG_BLOCK_LENGTH) live_block_len = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // out_stall pattern: mostly short stalls, occasional long ones
  always @(posedge clk) begin : sink_ctrl
    int unsigned p;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (sink_quiet) begin
      out_stall <= 1'b0;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 50) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(0, 15);
      end else if (p < 90) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else if (p < 98) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(3, 10);
      end else begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk) begin : result_check
    stereo_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (clipped_frames.size() == 0) begin
        $display("%0t: unexpected transfer left=%0d right=%0d", $time, left_out, right_out);
        fail_count++;
      end else begin
        want = clipped_frames.pop_front();
        if (left_out !== want.left_val) begin
          $display("%0t: left_out expected %0d actual %0d", $time, want.left_val, left_out);
          fail_count++;
        end
        if (right_out !== want.right_val) begin
          $display("%0t: right_out expected %0d actual %0d", $time, want.right_val, right_out);
          fail_count++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_frame(32'h7FFF_FFFF, 32'd30000, 1'b1, 14'd0);
    send_frame(32'h8000_0000, 32'd5, 1'b1, 14'd1);
    drain_pipeline();
  endtask

  task automatic test_silence_gating();
    write_reg(scc_pkg::REG_OUTPUT_ENABLE, 15'h0001);
    send_frame(32'd1000, 32'd2000, 1'b1, 14'd0);
    drain_pipeline();
    write_reg(scc_pkg::REG_BLOCK_LENGTH, 15'd3);
    send_frame(32'd40000, -32'sd40000, 1'b1, 14'd2);
    send_frame(32'd40000, -32'sd40000, 1'b1, 14'd3);
    send_frame(32'd40000, -32'sd40000, 1'b0, 14'd0);
    drain_pipeline();
    // bit 0 alone selects the enable
    write_reg(scc_pkg::REG_OUTPUT_ENABLE, 15'h7FFE);
    send_frame(32'd123, 32'd456, 1'b1, 14'd0);
    drain_pipeline();
    write_reg(scc_pkg::REG_OUTPUT_ENABLE, 15'h7FFF);
    write_reg(REG_SPARE_A, 15'h0000);
    write_reg(REG_SPARE_B, 15'h0000);
    send_frame(-32'sd777, 32'd24577, 1'b1, 14'd0);
    drain_pipeline();
  endtask

  task automatic test_clip_curve();
    write_reg(scc_pkg::REG_BLOCK_LENGTH, 15'd16384);
    send_frame(32'd0, 32'd24576, 1'b1, 14'd16383);
    send_frame(32'd24577, -32'sd24577, 1'b1, 14'd16383);
    send_frame(-32'sd24576, 32'd32767, 1'b1, 14'd16383);
    send_frame(32'd1000000, -32'sd1000000, 1'b1, 14'd16383);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 14'd16383);
    send_frame(32'h8000_0001, 32'hFFFF_FFFF, 1'b1, 14'd16383);
    send_frame(32'd1, 32'd49152, 1'b1, 14'd16383);
    drain_pipeline();
    write_reg(scc_pkg::REG_BLOCK_LENGTH, 15'h7FFF);
    send_frame(32'h4000_0000, 32'hC000_0000, 1'b1, 14'd16383);
    drain_pipeline();
    write_reg(scc_pkg::REG_BLOCK_LENGTH, 15'd16383);
    send_frame(32'd30000, 32'd30000, 1'b1, 14'd16383);
    send_frame(32'd30000, 32'd30000, 1'b1, 14'd16382);
    drain_pipeline();
  endtask

  task automatic test_random_phases();
    logic [scc_pkg::BLEN_W-1:0] lengths [10];
    int unsigned phase;
    int unsigned n;
    lengths = '{15'd16384, 15'd1, 15'h7FFF, 15'd16383, 15'd0,
                15'd100, 15'd8192, 15'd16384, 15'd2, 15'd12000};
    lengths[9] = 15'($urandom_range(2, 16383));
    for (phase = 0; phase < 10; phase++) begin
      drain_pipeline();
      src_quiet = (phase == 1 || phase == 2);
      sink_quiet = (phase == 2 || phase == 4);
      write_reg(phase[0] ? REG_SPARE_A : REG_SPARE_B, 15'($urandom));
      write_reg(scc_pkg::REG_OUTPUT_ENABLE, (15'($urandom) & 15'h7FFE) | 15'(phase != 3));
      write_reg(scc_pkg::REG_BLOCK_LENGTH, lengths[phase]);
      for (n = 0; n < FRAMES_PER_PHASE; n++) begin
        if (phase == 6 && n == FRAMES_PER_PHASE / 2) drain_pipeline();
        send_frame(rand_sample(), rand_sample(), $urandom_range(0, 9) != 0,
                   rand_frame_index());
      end
    end
    src_quiet = 1'b0;
    sink_quiet = 1'b0;
  endtask

  initial begin : run_tests
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_silence_gating();
    test_clip_curve();
    test_random_phases();
    in_valid <= 1'b0;
    waited = 0;
    while (clipped_frames.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (clipped_frames.size() != 0) begin
      $display("%0t: %0d transfers never arrived", $time, clipped_frames.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
